// ----- rtl/core/csbb_pkg.sv -----
package csbb_pkg;

	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int LIMIT_W = 16;
	// working width for endpoint sums and Horner values
	localparam int VAL_W   = 36;
	localparam int MULA_W  = 36;
	localparam int MULB_W  = 32;
	localparam int PROD_W  = MULA_W + MULB_W;
	localparam int RAD_W   = 66;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = 36;
	localparam int CNT_W   = 6;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [3:0][WORD_W-1:0] coefs_t;

	typedef enum logic [3:0] {
		AX_IDLE, AX_PREP, AX_SQA, AX_SQB, AX_DISC, AX_SQRT, AX_ROOTS,
		AX_CHECK, AX_DIV, AX_HLOAD, AX_HMUL, AX_HADD, AX_WIDEN, AX_NEXT, AX_DONE
	} ax_state_t;

	typedef enum logic [1:0] {
		TS_IDLE, TS_X, TS_Y, TS_EMIT
	} top_state_t;

	typedef struct packed {
		logic done;
		val_t lo;
		val_t hi;
	} axis_res_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	function automatic word_t sat_word(val_t v);
		word_t r;
		if (!v[VAL_W-1] && (v[VAL_W-2:WORD_W-1] != '0)) begin
			r = WORD_MAX;
		end else if (v[VAL_W-1] && (v[VAL_W-2:WORD_W-1] != '1)) begin
			r = WORD_MIN;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic val_t sext(logic [WORD_W-1:0] v);
		return {{(VAL_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

	function automatic logic [VAL_W-1:0] vmag(val_t v);
		return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

endpackage

// ----- rtl/core/cubic_spline_bounding_box.sv -----
// Bounding box of a shape built from cubic segments in power form, Q16.16.
// s_*: one transaction per segment. s_tdata holds x_coef0..x_coef3 then
// y_coef0..y_coef3, 32 bits each from bit 0 up; s_tlast marks the shape's
// last segment. m_*: one transaction per shape, taken on the last segment:
// m_tdata holds box_min_x, box_min_y, box_max_x, box_max_y from bit 0 up.
// cfg_*: writes near_zero_limit (cfg_data), accepted in every cycle.
// Each segment runs both axes in turn through one iterative engine: an
// axis takes a square root when the cubic coefficient is significant,
// then a division and a Horner evaluation for each interior candidate,
// the Horner steps on the single 36x32 multiplier. No new segment is
// taken until both axes are done and the box step is through; s_tready
// stays low meanwhile.
// After the second axis reports done, the emit step registers the box
// and holds it until m_tready; a further last segment waits for the held box to go.
// Reset empties the running box and sets the limit to 1.
module cubic_spline_bounding_box
	import csbb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [8*WORD_W-1:0] s_tdata,  // x_coef0..3, y_coef0..3
	input  logic                s_tlast,  // last_segment
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [4*WORD_W-1:0] m_tdata,  // box_min_x, box_min_y, box_max_x, box_max_y
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  cfg_data
);

	top_state_t state_q, state_n;
	logic [LIMIT_W-1:0] limit_q;
	coefs_t x_q, y_q;
	logic last_q, start_q, m_tvalid_q, emit_go, accept;
	logic [4*WORD_W-1:0] m_tdata_q;
	word_t run_min_x_q, run_min_y_q, run_max_x_q, run_max_y_q;
	word_t lo_sat, hi_sat;
	axis_res_t res;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign emit_go   = (state_q == TS_EMIT) && last_q && (!m_tvalid_q || m_tready);
	assign lo_sat    = sat_word(res.lo);
	assign hi_sat    = sat_word(res.hi);

	csbb_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.coef   ((state_q == TS_Y) ? y_q : x_q),
		.limit  (limit_q),
		.res    (res)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			TS_IDLE: if (accept) state_n = TS_X;
			TS_X:    if (res.done) state_n = TS_Y;
			TS_Y:    if (res.done) state_n = TS_EMIT;
			TS_EMIT: if (!last_q || emit_go) state_n = TS_IDLE;
			default: state_n = TS_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == TS_IDLE);
		m_tvalid = m_tvalid_q;
		m_tdata  = m_tdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			limit_q     <= LIMIT_W'(1);
			start_q     <= 1'b0;
			last_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			run_min_x_q <= WORD_MAX;
			run_min_y_q <= WORD_MAX;
			run_max_x_q <= WORD_MIN;
			run_max_y_q <= WORD_MIN;
		end else begin
			state_q <= state_n;
			start_q <= accept || ((state_q == TS_X) && res.done);
			if (cfg_valid) limit_q <= cfg_data;
			if (accept) last_q <= s_tlast;
			if ((state_q == TS_X) && res.done) begin
				if (lo_sat < run_min_x_q) run_min_x_q <= lo_sat;
				if (hi_sat > run_max_x_q) run_max_x_q <= hi_sat;
			end
			if ((state_q == TS_Y) && res.done) begin
				if (lo_sat < run_min_y_q) run_min_y_q <= lo_sat;
				if (hi_sat > run_max_y_q) run_max_y_q <= hi_sat;
			end
			if (emit_go) begin
				m_tvalid_q  <= 1'b1;
				run_min_x_q <= WORD_MAX;
				run_min_y_q <= WORD_MAX;
				run_max_x_q <= WORD_MIN;
				run_max_y_q <= WORD_MIN;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_tdata[4*WORD_W-1:0];
			y_q <= s_tdata[8*WORD_W-1:4*WORD_W];
		end
		if (emit_go) begin
			m_tdata_q <= {run_max_y_q, run_max_x_q, run_min_y_q, run_min_x_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == TS_EMIT))
		else $error("box emitted outside the emit step");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == TS_X || state_q == TS_Y))
		else $error("axis engine finished while no axis was requested");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (run_min_x_q == WORD_MAX && run_max_y_q == WORD_MIN))
		else $error("running box not cleared after emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !s_tready)
		else $error("axis started while input still open");

endmodule

// ----- rtl/core/csbb_axis.sv -----
module csbb_axis
	import csbb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  coefs_t             coef,
	input  logic [LIMIT_W-1:0] limit,
	output axis_res_t          res
);

	ax_state_t state_q, state_n;

	coefs_t c_q;
	val_t r0, r1, r2, r3;
	logic [VAL_W-1:0] m1, m2, m3;
	logic nz2, nz3;
	val_t e0, e1;

	logic [MULA_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod_q;

	logic [RAD_W-1:0] dsc_q, rad_q, b3, dsc_n;
	logic sd, no_root;
	logic [REM_W-1:0] rem_q, rem_t, trial;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;

	val_t n_q, d_q;
	logic [VAL_W-1:0] num_q, den_q, num2;
	logic [FRAC_W-1:0] t_q;
	logic cand_ok;
	logic quad_q, cand_q;

	val_t acc_q, acc_n, mf;
	logic [VAL_W-1:0] pmag;
	logic [1:0] idx_q;
	val_t lo_q, hi_q;

	assign r0 = sext(c_q[0]);
	assign r1 = sext(c_q[1]);
	assign r2 = sext(c_q[2]);
	assign r3 = sext(c_q[3]);
	assign m1 = vmag(r1);
	assign m2 = vmag(r2);
	assign m3 = vmag(r3);
	assign nz2 = (r2 == '0) || (m2 < VAL_W'(limit));
	assign nz3 = (r3 == '0) || (m3 < VAL_W'(limit));
	assign e0 = r0;
	assign e1 = r0 + r1 + r2 + r3;

	always_comb begin
		unique case (state_q)
			AX_SQA: begin
				mul_a = MULA_W'(m2);
				mul_b = m2[MULB_W-1:0];
			end
			AX_SQB: begin
				mul_a = MULA_W'(m3);
				mul_b = m1[MULB_W-1:0];
			end
			default: begin
				mul_a = MULA_W'(vmag(acc_q));
				mul_b = MULB_W'(t_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// discriminant r2^2 - 3 r3 r1, formed on magnitudes
	assign b3 = RAD_W'(prod_q[63:0]) + {1'b0, prod_q[63:0], 1'b0};
	assign sd = (r1 != '0) && (r1[VAL_W-1] != r3[VAL_W-1]);
	assign dsc_n = sd ? dsc_q + b3 : dsc_q - b3;
	assign no_root = sd ? (dsc_n == '0) : (dsc_q <= b3);

	assign rem_t = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial = REM_W'({root_q, 2'b01});

	assign cand_ok = (n_q != '0) && (n_q[VAL_W-1] == d_q[VAL_W-1]) && (vmag(n_q) < vmag(d_q));
	assign num2 = {num_q[VAL_W-2:0], 1'b0};

	assign pmag = prod_q[FRAC_W+VAL_W-1:FRAC_W];
	assign mf = acc_q[VAL_W-1] ? -val_t'(pmag) : val_t'(pmag);
	assign acc_n = sext(c_q[idx_q]) + mf;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			AX_IDLE:  if (start) state_n = AX_PREP;
			AX_PREP: begin
				if (!nz3) state_n = AX_SQA;
				else if (nz2) state_n = AX_DONE;
				else state_n = AX_CHECK;
			end
			AX_SQA:   state_n = AX_SQB;
			AX_SQB:   state_n = AX_DISC;
			AX_DISC:  state_n = no_root ? AX_DONE : AX_SQRT;
			AX_SQRT:  if (cnt_q == '0) state_n = AX_ROOTS;
			AX_ROOTS: state_n = AX_CHECK;
			AX_CHECK: state_n = cand_ok ? AX_DIV : AX_NEXT;
			AX_DIV:   if (cnt_q == '0) state_n = AX_HLOAD;
			AX_HLOAD: state_n = AX_HMUL;
			AX_HMUL:  state_n = AX_HADD;
			AX_HADD:  state_n = (idx_q == '0) ? AX_WIDEN : AX_HMUL;
			AX_WIDEN: state_n = AX_NEXT;
			AX_NEXT:  state_n = (!quad_q && !cand_q) ? AX_CHECK : AX_DONE;
			AX_DONE:  state_n = AX_IDLE;
			default:  state_n = AX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			AX_IDLE: begin
				if (start) c_q <= coef;
			end
			AX_PREP: begin
				lo_q   <= (e0 < e1) ? e0 : e1;
				hi_q   <= (e0 < e1) ? e1 : e0;
				quad_q <= nz3;
				cand_q <= 1'b0;
				n_q    <= r1;
				d_q    <= -(r2 <<< 1);
			end
			AX_SQB: dsc_q <= RAD_W'(prod_q);
			AX_DISC: begin
				rad_q  <= dsc_n;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end
			AX_SQRT: begin
				rad_q <= rad_q << 2;
				cnt_q <= cnt_q - 1'b1;
				if (rem_t >= trial) begin
					rem_q  <= rem_t - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_t;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			AX_ROOTS: begin
				n_q <= -r2 - val_t'(root_q);
				d_q <= r3 + (r3 <<< 1);
			end
			AX_CHECK: begin
				num_q <= vmag(n_q);
				den_q <= vmag(d_q);
				t_q   <= '0;
				cnt_q <= CNT_W'(FRAC_W - 1);
			end
			AX_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				if (num2 >= den_q) begin
					num_q <= num2 - den_q;
					t_q   <= {t_q[FRAC_W-2:0], 1'b1};
				end else begin
					num_q <= num2;
					t_q   <= {t_q[FRAC_W-2:0], 1'b0};
				end
			end
			AX_HLOAD: begin
				acc_q <= quad_q ? r2 : r3;
				idx_q <= quad_q ? 2'd1 : 2'd2;
			end
			AX_HADD: begin
				acc_q <= acc_n;
				if (idx_q != '0) idx_q <= idx_q - 1'b1;
			end
			AX_WIDEN: begin
				if (acc_q < lo_q) lo_q <= acc_q;
				if (acc_q > hi_q) hi_q <= acc_q;
			end
			AX_NEXT: begin
				// second root of the derivative
				cand_q <= 1'b1;
				n_q    <= -r2 + val_t'(root_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		res.done = (state_q == AX_DONE);
		res.lo   = lo_q;
		res.hi   = hi_q;
	end

endmodule

// ----- tb/sv/cubic_spline_bounding_box_tb.sv -----
`timescale 1ns / 100ps

module cubic_spline_bounding_box_tb;
	import csbb_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [31:0] cf [8];
		logic        last_seg;
	} segment_t;

	typedef struct {
		logic [31:0] min_x, min_y, max_x, max_y;
	} box_t;

	typedef struct {
		bit          has_box;
		segment_t    seg;
		box_t        box;
		logic [15:0] limit;
		bit          is_cfg;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [8*WORD_W-1:0] s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [4*WORD_W-1:0] m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_data = '0;

	cubic_spline_bounding_box u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [15:0] zero_limit;
	longint      acc_min_x, acc_min_y, acc_max_x, acc_max_y;
	box_t        box_queue [$];
	bit          failed = 1'b0;
	bit          stim_done = 1'b0;
	int          cycles = 0;
	int          stall_left = 0;

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit is_negligible(longint v);
		return v == 0 || magnitude(v) < longint'(zero_limit);
	endfunction

	function automatic longint clamp_word(longint v);
		return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
	endfunction

	function automatic longint unsigned frac_quotient(longint unsigned num,
			longint unsigned den);
		longint unsigned q, rem;
		q = 0;
		rem = num;
		for (int i = 0; i < FRAC_W; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic longint scale_by_t(longint v, longint unsigned t);
		longint unsigned m, p;
		m = magnitude(v);
		p = (m >> FRAC_W) * t + (((m & 64'hFFFF) * t) >> FRAC_W);
		return v < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] d);
		logic [63:0]  r, c;
		logic [127:0] sq;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			sq = 128'(c) * 128'(c);
			if (sq <= d) r = c;
		end
		return r;
	endfunction

	function automatic void stretch(longint y, ref longint lo, ref longint hi);
		if (y < lo) lo = y;
		if (y > hi) hi = y;
	endfunction

	// value at interior candidate n/d, skipped unless 0 < n/d < 1
	function automatic void try_root(longint n, longint d, longint c[4],
			ref longint lo, ref longint hi);
		longint unsigned t;
		if (n == 0 || ((n < 0) != (d < 0)) || magnitude(n) >= magnitude(d)) return;
		t = frac_quotient(magnitude(n), magnitude(d));
		stretch(c[0] + scale_by_t(c[1] + scale_by_t(c[2] + scale_by_t(c[3], t), t), t),
			lo, hi);
	endfunction

	function automatic void axis_extent(longint c[4], ref longint lo, ref longint hi);
		longint      e0, e1, s;
		longint unsigned t;
		logic [127:0] sq2, p31, disc;
		e0 = c[0];
		e1 = c[0] + c[1] + c[2] + c[3];
		lo = e0 < e1 ? e0 : e1;
		hi = e0 < e1 ? e1 : e0;
		if (is_negligible(c[3])) begin
			if (is_negligible(c[2])) return;
			if (c[1] == 0 || ((c[1] < 0) == (c[2] < 0))
					|| magnitude(c[1]) >= 2 * magnitude(c[2])) return;
			t = frac_quotient(magnitude(c[1]), 2 * magnitude(c[2]));
			stretch(c[0] + scale_by_t(c[1] + scale_by_t(c[2], t), t), lo, hi);
		end else begin
			sq2 = 128'(magnitude(c[2])) * 128'(magnitude(c[2]));
			p31 = 128'(3 * magnitude(c[3])) * 128'(magnitude(c[1]));
			if (c[1] == 0) disc = sq2;
			else if ((c[1] < 0) != (c[3] < 0)) disc = sq2 + p31;
			else if (sq2 <= p31) return;
			else disc = sq2 - p31;
			if (disc == 0) return;
			s = longint'(root_floor(disc));
			try_root(-c[2] - s, 3 * c[3], c, lo, hi);
			try_root(-c[2] + s, 3 * c[3], c, lo, hi);
		end
	endfunction

	function automatic void clear_box();
		acc_min_x = VMAX;
		acc_min_y = VMAX;
		acc_max_x = VMIN;
		acc_max_y = VMIN;
	endfunction

	function automatic void predict_segment(segment_t sg);
		longint cx[4], cy[4], lo, hi;
		box_t   b;
		for (int i = 0; i < 4; i++) begin
			cx[i] = longint'(signed'(sg.cf[i]));
			cy[i] = longint'(signed'(sg.cf[4+i]));
		end
		axis_extent(cx, lo, hi);
		lo = clamp_word(lo);
		hi = clamp_word(hi);
		if (lo < acc_min_x) acc_min_x = lo;
		if (hi > acc_max_x) acc_max_x = hi;
		axis_extent(cy, lo, hi);
		lo = clamp_word(lo);
		hi = clamp_word(hi);
		if (lo < acc_min_y) acc_min_y = lo;
		if (hi > acc_max_y) acc_max_y = hi;
		if (sg.last_seg) begin
			b.min_x = acc_min_x[31:0];
			b.min_y = acc_min_y[31:0];
			b.max_x = acc_max_x[31:0];
			b.max_y = acc_max_y[31:0];
			box_queue = {box_queue, b};
			clear_box();
		end
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// keep tvalid high straight into the next transaction when there is no gap
	task automatic send_segment(segment_t sg);
		int gap;
		gap = short_or_long_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			wait_cycles(gap);
		end
		for (int i = 0; i < 8; i++) s_tdata[32*i +: 32] <= sg.cf[i];
		s_tlast  <= sg.last_seg;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_segment(sg);
	endtask

	task automatic drain_and_settle();
		while (box_queue.size() != 0) @(posedge clk);
		wait_cycles(250);
	endtask

	task automatic write_limit(logic [15:0] v);
		s_tvalid <= 1'b0;
		drain_and_settle();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		zero_limit = v;
	endtask

	function automatic logic [31:0] random_coef();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'($signed($urandom_range(0, 4)) - 2);
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	function automatic segment_t random_segment(bit end_run);
		segment_t sg;
		for (int i = 0; i < 8; i++) sg.cf[i] = random_coef();
		sg.last_seg = end_run;
		return sg;
	endfunction

	function automatic segment_t make_seg(longint a0, longint a1, longint a2, longint a3,
			longint b0, longint b1, longint b2, longint b3, bit lst);
		segment_t sg;
		sg.cf[0] = a0[31:0]; sg.cf[1] = a1[31:0]; sg.cf[2] = a2[31:0];
		sg.cf[3] = a3[31:0]; sg.cf[4] = b0[31:0]; sg.cf[5] = b1[31:0];
		sg.cf[6] = b2[31:0]; sg.cf[7] = b3[31:0];
		sg.last_seg = lst;
		return sg;
	endfunction

	// output side: random backpressure and comparison
	always @(posedge clk) begin
		box_t b;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (box_queue.size() == 0) begin
					$error("box transaction with none expected");
					failed = 1'b1;
				end else begin
					b = box_queue.pop_front();
					if (m_tdata[31:0] !== b.min_x) begin
						$error("box_min_x exp %h got %h", b.min_x, m_tdata[31:0]);
						failed = 1'b1;
					end
					if (m_tdata[63:32] !== b.min_y) begin
						$error("box_min_y exp %h got %h", b.min_y, m_tdata[63:32]);
						failed = 1'b1;
					end
					if (m_tdata[95:64] !== b.max_x) begin
						$error("box_max_x exp %h got %h", b.max_x, m_tdata[95:64]);
						failed = 1'b1;
					end
					if (m_tdata[127:96] !== b.max_y) begin
						$error("box_max_y exp %h got %h", b.max_y, m_tdata[127:96]);
						failed = 1'b1;
					end
				end
			end
			// mostly short stalls, now and then a long one
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if ($urandom_range(0, 63) == 0) begin
				stall_left <= $urandom_range(20, 150);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 9) < 6) ||
					(stim_done && $urandom_range(0, 1));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	row_t directed [$];

	task automatic add_seg(segment_t sg);
		row_t r;
		r.is_cfg = 0;
		r.has_box = 0;
		r.seg = sg;
		directed = {directed, r};
	endtask

	task automatic add_seg_box(segment_t sg, longint mnx, longint mny, longint mxx,
			longint mxy);
		row_t r;
		r.is_cfg = 0;
		r.has_box = 1;
		r.seg = sg;
		r.box.min_x = mnx[31:0]; r.box.min_y = mny[31:0];
		r.box.max_x = mxx[31:0]; r.box.max_y = mxy[31:0];
		directed = {directed, r};
	endtask

	task automatic add_cfg(logic [15:0] v);
		row_t r;
		r.is_cfg = 1;
		r.limit = v;
		directed = {directed, r};
	endtask

	initial begin
		box_t    tail;
		int      run_len;
		zero_limit = 16'd1;
		clear_box();
		// directed rows
		add_seg_box(make_seg(0, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);
		add_seg_box(make_seg(65536, 65536, 0, 0, -65536, 131072, 0, 0, 1),
			65536, -65536, 131072, 65536);
		add_seg_box(make_seg(VMAX, VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, VMIN, 1),
			VMAX, VMIN, VMAX, VMIN);
		add_seg(make_seg(0, 65536, -65536, 0, 0, -131072, 65536, 0, 1));
		add_seg(make_seg(0, 0, 196608, -131072, 0, 65536, -196608, 131072, 1));
		add_seg(make_seg(0, 131072, -65536, 0, 5, 1, 2, 3, 0));
		add_seg(make_seg(-1, 1, -1, 1, 100, -300, 300, -100, 1));
		add_seg(make_seg(VMIN, -1, -1, 0, VMAX, 1, 1, 0, 1));
		add_cfg(16'd0);
		add_seg(make_seg(0, 1, -1, 0, 0, 0, 0, 0, 1));
		add_seg(make_seg(0, 0, 3, -2, 7, 0, 1, 0, 1));
		add_cfg(16'hFFFF);
		add_seg(make_seg(0, 65536, -65535, 0, 0, 0, 65536, -65535, 1));
		add_seg(make_seg(0, 65536, -196608, 131072, 1, 2, 3, 4, 1));
		add_cfg(16'd1);

		wait_cycles(8);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				write_limit(directed[i].limit);
			end else begin
				send_segment(directed[i].seg);
				if (directed[i].has_box) begin
					// hand-typed box must match the predictor's entry
					tail = box_queue[$];
					if (tail.min_x !== directed[i].box.min_x) begin
						$error("row %0d box_min_x exp %h pred %h", i,
							directed[i].box.min_x, tail.min_x);
						failed = 1'b1;
					end
					if (tail.min_y !== directed[i].box.min_y) begin
						$error("row %0d box_min_y exp %h pred %h", i,
							directed[i].box.min_y, tail.min_y);
						failed = 1'b1;
					end
					if (tail.max_x !== directed[i].box.max_x) begin
						$error("row %0d box_max_x exp %h pred %h", i,
							directed[i].box.max_x, tail.max_x);
						failed = 1'b1;
					end
					if (tail.max_y !== directed[i].box.max_y) begin
						$error("row %0d box_max_y exp %h pred %h", i,
							directed[i].box.max_y, tail.max_y);
						failed = 1'b1;
					end
					box_queue[$] = directed[i].box;
				end
			end
		end

		// random shapes, limit changed between phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_limit(16'd1);
				1: write_limit(16'($urandom_range(2, 65534)));
				2: write_limit(16'hFFFF);
				default: write_limit(16'd0);
			endcase
			for (int n = 0; n < 200; n += run_len) begin
				run_len = $urandom_range(1, 6);
				for (int k = 0; k < run_len; k++) send_segment(random_segment(k == run_len - 1));
			end
		end

		s_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (box_queue.size() != 0) @(posedge clk);
		wait_cycles(250);
		if (!failed) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
